// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CHAN_W    = FRAC_BITS + 1;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  // 1.0 in Q1.FRAC_BITS
  localparam chan_t ONE = chan_t'(1) << FRAC_BITS;

  // Hue sector, one per sixth of the color wheel
  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t brightness;
    chan_t opacity_in;
  } hsv_word_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t opacity_out;
  } rgb_word_t;

endpackage

// ===== design/hsv2rgb_fxmul.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_fxmul
// Registered fixed point multiply, product truncated by FRAC_BITS.
// ----------------------------------------------------------------------------
module hsv2rgb_fxmul (
  input  logic               clk,
  input  logic               en,
  input  hsv2rgb_pkg::chan_t a,
  input  hsv2rgb_pkg::chan_t b,
  output hsv2rgb_pkg::chan_t y
);
  import hsv2rgb_pkg::*;

  logic [2*CHAN_W-1:0] prod;

  assign prod = {{CHAN_W{1'b0}}, a} * {{CHAN_W{1'b0}}, b};

  // both operands are at most ONE, so the shifted product fits CHAN_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      y <= prod[FRAC_BITS +: CHAN_W];
    end
  end

endmodule

// ===== design/hsv_to_rgb_pixel_convert_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_convert_core
// Streaming HSV plus alpha to RGB plus alpha converter, Q1.16 channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel hsv_valid / hsv_ready / hsv carries one HSV word per
//   handshake; output channel rgb_valid / rgb_ready / rgb returns one RGB
//   word for each input word, in order.
//   Hue, saturation and brightness above 1.0 are clamped to 1.0; alpha is
//   copied unchanged.
// Pipeline: four register stages from input handshake to rgb_valid, the
//   first loaded at the accepting edge.
//   stage 1: clamp, hue*6, sector and fraction
//   stage 2: s*f, s*(1-f), v*(1-s)   (three multipliers)
//   stage 3: q and t                 (two multipliers)
//   stage 4: sector routing into the output register
// Throughput: one word per cycle while rgb_ready stays high; every stage
//   can take a new word in the cycle its current word moves on.
// Reset: rst (synchronous) empties all four stages; payload regs are not
//   cleared.
// Stall: when rgb_ready is low, the stages fill up behind the output
//   register; hsv_ready drops only once every stage holds a word. Nothing
//   is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_convert_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   hsv_valid,
  output logic                   hsv_ready,
  input  hsv2rgb_pkg::hsv_word_t hsv,
  output logic                   rgb_valid,
  input  logic                   rgb_ready,
  output hsv2rgb_pkg::rgb_word_t rgb
);
  import hsv2rgb_pkg::*;

  // stage valids and enables; a stage loads when empty or when it drains
  logic vld1, vld2, vld3;
  logic en1, en2, en3, en4;

  assign en4       = !rgb_valid || rgb_ready;
  assign en3       = !vld3 || en4;
  assign en2       = !vld2 || en3;
  assign en1       = !vld1 || en2;
  assign hsv_ready = en1;

  // ---------------- stage 1: clamp, hue*6, sector ----------------
  chan_t                h_c, s_c, v_c;
  logic [CHAN_W+1:0]    h6;
  logic [2:0]           ipart;
  sector_t              sect_c;

  assign h_c = (hsv.hue        > ONE) ? ONE : hsv.hue;
  assign s_c = (hsv.saturation > ONE) ? ONE : hsv.saturation;
  assign v_c = (hsv.brightness > ONE) ? ONE : hsv.brightness;

  // h*6 = h*4 + h*2; integer part is 0..6, six wraps to sector 0
  assign h6    = {h_c, 2'b00} + {1'b0, h_c, 1'b0};
  assign ipart = h6[FRAC_BITS +: 3];

  always_comb begin
    case (ipart)
      3'd1:    sect_c = SECT_YELLOW;
      3'd2:    sect_c = SECT_GREEN;
      3'd3:    sect_c = SECT_CYAN;
      3'd4:    sect_c = SECT_BLUE;
      3'd5:    sect_c = SECT_MAGENTA;
      default: sect_c = SECT_RED;
    endcase
  end

  chan_t   s1, v1, a1, oms1;
  frac_t   f1;
  sector_t sect1;
  logic    grey1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en1) begin
      vld1 <= hsv_valid;
    end
    if (en1) begin
      s1    <= s_c;
      v1    <= v_c;
      a1    <= hsv.opacity_in;
      oms1  <= ONE - s_c;
      f1    <= h6[FRAC_BITS-1:0];
      sect1 <= sect_c;
      grey1 <= (s_c == '0);
    end
  end

  // ---------------- stage 2: first products ----------------
  chan_t   sf2, s1f2, p2;
  chan_t   v2, a2;
  sector_t sect2;
  logic    grey2;

  hsv2rgb_fxmul u_mul_sf (
    .clk (clk), .en (en2), .a (s1), .b ({1'b0, f1}), .y (sf2)
  );

  hsv2rgb_fxmul u_mul_s1f (
    .clk (clk), .en (en2), .a (s1), .b (ONE - {1'b0, f1}), .y (s1f2)
  );

  hsv2rgb_fxmul u_mul_p (
    .clk (clk), .en (en2), .a (v1), .b (oms1), .y (p2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en2) begin
      vld2 <= vld1;
    end
    if (en2) begin
      v2    <= v1;
      a2    <= a1;
      sect2 <= sect1;
      grey2 <= grey1;
    end
  end

  // ---------------- stage 3: q and t ----------------
  chan_t   q3, t3, p3, v3, a3;
  sector_t sect3;
  logic    grey3;

  hsv2rgb_fxmul u_mul_q (
    .clk (clk), .en (en3), .a (v2), .b (ONE - sf2), .y (q3)
  );

  hsv2rgb_fxmul u_mul_t (
    .clk (clk), .en (en3), .a (v2), .b (ONE - s1f2), .y (t3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en3) begin
      vld3 <= vld2;
    end
    if (en3) begin
      p3    <= p2;
      v3    <= v2;
      a3    <= a2;
      sect3 <= sect2;
      grey3 <= grey2;
    end
  end

  // ---------------- stage 4: sector routing ----------------
  rgb_word_t rgb_next;

  always_comb begin
    rgb_next.opacity_out = a3;
    if (grey3) begin
      rgb_next.red   = v3;
      rgb_next.green = v3;
      rgb_next.blue  = v3;
    end else begin
      case (sect3)
        SECT_RED: begin
          rgb_next.red = v3; rgb_next.green = t3; rgb_next.blue = p3;
        end
        SECT_YELLOW: begin
          rgb_next.red = q3; rgb_next.green = v3; rgb_next.blue = p3;
        end
        SECT_GREEN: begin
          rgb_next.red = p3; rgb_next.green = v3; rgb_next.blue = t3;
        end
        SECT_CYAN: begin
          rgb_next.red = p3; rgb_next.green = q3; rgb_next.blue = v3;
        end
        SECT_BLUE: begin
          rgb_next.red = t3; rgb_next.green = p3; rgb_next.blue = v3;
        end
        default: begin
          rgb_next.red = v3; rgb_next.green = p3; rgb_next.blue = q3;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (en4) begin
      rgb_valid <= vld3;
    end
    if (en4) begin
      rgb <= rgb_next;
    end
  end

  // ---------------- assertions ----------------
  // color channels never leave 0..1.0
  a_rgb_range: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> (rgb.red <= ONE) && (rgb.green <= ONE) && (rgb.blue <= ONE))
    else $error("rgb channel above 1.0");

  // a grey word leaves with equal channels
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (vld3 && grey3 && en4) |=> (rgb.red == rgb.green) && (rgb.green == rgb.blue))
    else $error("grey word not grey");

  // a stalled word in stage 3 is kept
  a_hold3: assert property (@(posedge clk) disable iff (rst)
    (vld3 && !en4) |=> vld3)
    else $error("stage 3 word lost during stall");

  // input backpressure only when the whole pipe is full
  a_full: assert property (@(posedge clk) disable iff (rst)
    !hsv_ready |-> (vld1 && vld2 && vld3 && rgb_valid && !rgb_ready))
    else $error("hsv_ready low with a free stage");

endmodule
